// ===== hdl/smc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the sliding mode controller.
// Used by the interfaces, the controller, the datapath, the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package smc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned GAIN_W = 31;
  localparam int unsigned EXPO_W = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W = 5;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOPE    = 3'd0,
    CFG_GAIN     = 3'd1,
    CFG_EPS      = 3'd2,
    CFG_EXPO     = 3'd3,
    CFG_MODE     = 3'd4,
    CFG_BOUNDARY = 3'd5,
    CFG_DMIN     = 3'd6,
    CFG_DMAX     = 3'd7
  } cfg_idx_t;

  // Reaching law codes
  typedef enum logic [1:0] {
    LAW_CONST  = 2'd0,
    LAW_EXP    = 2'd1,
    LAW_POWER  = 2'd2,
    LAW_CONST2 = 2'd3
  } law_t;

  // Datapath operations issued by the controller
  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_ERR, OP_RATE, OP_SURF, OP_SVINIT, OP_DIV, OP_SVDIV,
    OP_PW_ONE, OP_PW_ZERO, OP_SQ_INIT, OP_SQ, OP_PW_SQ,
    OP_NORM_INIT, OP_NORM, OP_LG_INIT, OP_LG_M, OP_LG_U, OP_LY,
    OP_EX_INIT, OP_EX_M, OP_EX_U, OP_EX_F,
    OP_PSV, OP_T3, OP_KT3, OP_KSV, OP_T1, OP_EPS, OP_UR_EXP, OP_UR_CON,
    OP_CED, OP_U, OP_F1, OP_F1U, OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic big;
    logic [1:0] mode;
    logic alpha_zero;
    logic alpha_half;
    logic x_zero;
    logic norm_done;
    logic out_free;
  } dp_sts_t;

  localparam logic [GAIN_W-1:0] RST_SLOPE    = 31'd65536;
  localparam logic [GAIN_W-1:0] RST_GAIN     = 31'd65536;
  localparam logic [GAIN_W-1:0] RST_EPS      = 31'd32768;
  localparam logic [EXPO_W-1:0] RST_EXPO     = 17'd32768;
  localparam logic [EXPO_W-1:0] EXPO_ONE     = 17'd65536;
  localparam logic [EXPO_W-1:0] EXPO_HALF    = 17'd32768;
  localparam logic [1:0]        RST_MODE     = 2'd1;
  localparam logic [GAIN_W-1:0] RST_BOUNDARY = 31'd6554;
  localparam logic signed [DATA_W-1:0] RST_DMIN = -32'sd65536000;
  localparam logic signed [DATA_W-1:0] RST_DMAX = 32'sd65536000;

  localparam logic signed [32:0] FILT_NEW = 33'sd19661;
  localparam logic signed [32:0] FILT_OLD = 33'sd45875;
  localparam logic signed [32:0] Q30_ONE  = 33'sd1073741824;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [65:0] ext66(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  // Integer square root, used only at elaboration for the factor table
  function automatic logic [63:0] isqrt_const(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  typedef logic [30:0] fact_tab_t [0:16];

  // 2^(2^-i) in Q1.30, each the truncated root of the one before
  function automatic fact_tab_t build_fact();
    fact_tab_t t;
    logic [63:0] r;
    r = 64'd2 << 30;
    t[0] = '0;
    for (int i = 1; i <= 16; i++) begin
      r = isqrt_const(r << 30);
      t[i] = r[30:0];
    end
    return t;
  endfunction

  localparam fact_tab_t EXP2_FACT = build_fact();

endpackage

// ===== hdl/smc_ifs.sv =====
// Handshake channel interfaces for the sliding mode controller.
// Depends on smc_pkg for the field width.
`timescale 1ns / 1ps

interface smc_in_if import smc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] measured_rate;
  modport source (output valid, setpoint, measured, measured_rate, input ready);
  modport sink (input valid, setpoint, measured, measured_rate, output ready);
endinterface

interface smc_out_if import smc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] surface;
  modport source (output valid, drive, surface, input ready);
  modport sink (input valid, drive, surface, output ready);
endinterface

// ===== hdl/smc_ctrl.sv =====
// Sequencer of the sliding mode controller: at most one datapath operation a cycle.
// Depends on smc_pkg for command and status types.
`timescale 1ns / 1ps

module smc_ctrl import smc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_ERR, ST_RATE, ST_WAIT, ST_SURF, ST_SVINIT, ST_DIV, ST_SVDIV,
    ST_BRANCH, ST_PSEL, ST_SQ, ST_PW_SQ, ST_NORM, ST_LG_M, ST_LG_U, ST_LY,
    ST_EX_INIT, ST_EX_M, ST_EX_U, ST_EX_F, ST_PSV, ST_T3, ST_KT3, ST_KSV,
    ST_T1, ST_EPS, ST_URE, ST_URC, ST_CED, ST_U, ST_F1, ST_F1U, ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  state_t           ret_r, ret_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state and the operation of this cycle
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.idx   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.op = OP_ERR;
        state_nxt = ST_RATE;
      end
      ST_RATE: begin
        cmd.op = OP_RATE;
        state_nxt = ST_WAIT;
        ret_nxt = ST_SURF;
      end
      ST_WAIT: state_nxt = ret_r;
      ST_SURF: begin
        cmd.op = OP_SURF;
        state_nxt = ST_SVINIT;
      end
      ST_SVINIT: begin
        cmd.op = OP_SVINIT;
        cnt_nxt = '0;
        state_nxt = sts.big ? ST_BRANCH : ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd16) state_nxt = ST_SVDIV;
      end
      ST_SVDIV: begin
        cmd.op = OP_SVDIV;
        state_nxt = ST_BRANCH;
      end
      ST_BRANCH: state_nxt = (sts.mode == LAW_POWER) ? ST_PSEL : ST_KSV;
      ST_PSEL: begin
        cnt_nxt = '0;
        if (sts.alpha_zero) begin
          cmd.op = OP_PW_ONE;
          state_nxt = ST_PSV;
        end else if (sts.x_zero) begin
          cmd.op = OP_PW_ZERO;
          state_nxt = ST_PSV;
        end else if (sts.alpha_half) begin
          cmd.op = OP_SQ_INIT;
          state_nxt = ST_SQ;
        end else begin
          cmd.op = OP_NORM_INIT;
          state_nxt = ST_NORM;
        end
      end
      ST_SQ: begin
        cmd.op = OP_SQ;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) state_nxt = ST_PW_SQ;
      end
      ST_PW_SQ: begin
        cmd.op = OP_PW_SQ;
        state_nxt = ST_PSV;
      end
      ST_NORM: begin
        if (sts.norm_done) begin
          cmd.op = OP_LG_INIT;
          cnt_nxt = '0;
          state_nxt = ST_LG_M;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      ST_LG_M: begin
        cmd.op = OP_LG_M;
        state_nxt = ST_WAIT;
        ret_nxt = ST_LG_U;
      end
      ST_LG_U: begin
        cmd.op = OP_LG_U;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r == 5'd15) ? ST_LY : ST_LG_M;
      end
      ST_LY: begin
        cmd.op = OP_LY;
        state_nxt = ST_WAIT;
        ret_nxt = ST_EX_INIT;
      end
      ST_EX_INIT: begin
        cmd.op = OP_EX_INIT;
        cnt_nxt = 5'd1;
        state_nxt = ST_EX_M;
      end
      ST_EX_M: begin
        cmd.op = OP_EX_M;
        state_nxt = ST_WAIT;
        ret_nxt = ST_EX_U;
      end
      ST_EX_U: begin
        cmd.op = OP_EX_U;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r == 5'd16) ? ST_EX_F : ST_EX_M;
      end
      ST_EX_F: begin
        cmd.op = OP_EX_F;
        state_nxt = ST_PSV;
      end
      ST_PSV: begin
        cmd.op = OP_PSV;
        state_nxt = ST_WAIT;
        ret_nxt = ST_T3;
      end
      ST_T3: begin
        cmd.op = OP_T3;
        state_nxt = ST_KT3;
      end
      ST_KT3: begin
        cmd.op = OP_KT3;
        state_nxt = ST_WAIT;
        ret_nxt = ST_T1;
      end
      ST_KSV: begin
        cmd.op = OP_KSV;
        state_nxt = ST_WAIT;
        ret_nxt = ST_T1;
      end
      ST_T1: begin
        cmd.op = OP_T1;
        state_nxt = (sts.mode == LAW_EXP) ? ST_EPS : ST_URC;
      end
      ST_EPS: begin
        cmd.op = OP_EPS;
        state_nxt = ST_WAIT;
        ret_nxt = ST_URE;
      end
      ST_URE: begin
        cmd.op = OP_UR_EXP;
        state_nxt = ST_CED;
      end
      ST_URC: begin
        cmd.op = OP_UR_CON;
        state_nxt = ST_CED;
      end
      ST_CED: begin
        cmd.op = OP_CED;
        state_nxt = ST_WAIT;
        ret_nxt = ST_U;
      end
      ST_U: begin
        cmd.op = OP_U;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        cmd.op = OP_F1;
        state_nxt = ST_WAIT;
        ret_nxt = ST_F1U;
      end
      ST_F1U: begin
        cmd.op = OP_F1U;
        state_nxt = ST_WAIT;
        ret_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.op = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, return point and loop count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !sts.out_free) |=> state_r == ST_FIN)
    else $error("result dropped while output slot busy");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SVDIV) |-> $past(state_r) == ST_DIV && $past(cnt_r) == 5'd16)
    else $error("divider left early");
  a_wait_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> ret_r != ST_WAIT && ret_r != ST_IDLE)
    else $error("bad return state");

endmodule

// ===== hdl/smc_dp.sv =====
// Datapath of the sliding mode controller: config registers, shared multiplier,
// divider, square root and log/exp loops, state and output register. Uses smc_pkg.
`timescale 1ns / 1ps

module smc_dp import smc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic signed [DATA_W-1:0] in_setpoint,
  input  logic signed [DATA_W-1:0] in_measured,
  input  logic signed [DATA_W-1:0] in_measured_rate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_drive,
  output logic signed [DATA_W-1:0] out_surface
);

  // Configuration
  logic [GAIN_W-1:0] slope_r, gain_r, eps_r, bnd_r;
  logic [EXPO_W-1:0] expo_r;
  logic [1:0]        mode_r;
  logic signed [DATA_W-1:0] dmin_r, dmax_r;

  // Sample and working registers
  logic signed [31:0] sp_r, ms_r, rt_r, e_r, ed_r, s_r, prev_r, fd_r;
  logic signed [31:0] pw_r, t1_r, t3_r, ur_r, u_r;
  logic [32:0]        bl_r, rem_r, m_r;
  logic [16:0]        q_r, num_r;
  logic signed [17:0] sv_r;
  logic [63:0]        sqv_r, sqr_r, sqb_r;
  logic [31:0]        nx_r;
  logic [4:0]         lp_r;
  logic [15:0]        frac_r;
  logic signed [22:0] y_r;
  logic signed [32:0] ma_r, mb_r;
  logic signed [65:0] prod_r, acc_r;
  logic               out_valid_r;
  logic signed [31:0] out_drive_r, out_surf_r;

  // Combinational helpers
  logic signed [31:0] qm;
  logic signed [32:0] e33, s33;
  logic [32:0]        ae, as33;
  logic [31:0]        as32;
  logic [34:0]        tenb;
  logic [32:0]        bl_sel;
  logic signed [65:0] diff, d100;
  logic [33:0]        trial;
  logic [63:0]        sq_t;
  logic [32:0]        mm;
  logic signed [5:0]  lpm;
  logic signed [21:0] lval;
  logic [3:0]         bsel;
  logic [4:0]         bsel5;
  logic signed [6:0]  ip;
  logic [6:0]         sh7;
  logic [32:0]        up1;
  logic signed [31:0] filt, clamp;

  always_comb begin
    qm    = sat32(prod_r >>> 16);
    e33   = {e_r[31], e_r};
    s33   = {s_r[31], s_r};
    ae    = e_r[31] ? 33'(-e33) : 33'(e33);
    as33  = s_r[31] ? 33'(-s33) : 33'(s33);
    as32  = as33[31:0];
    tenb  = {1'b0, bnd_r, 3'b000} + {3'b000, bnd_r, 1'b0};
    diff  = ext66(e_r) - ext66(prev_r);
    d100  = (diff <<< 6) + (diff <<< 5) + (diff <<< 2);
    trial = {rem_r, num_r[16]};
    sq_t  = sqr_r + sqb_r;
    mm    = prod_r[62:30];
    lpm   = $signed({1'b0, lp_r}) - 6'sd16;
    lval  = $signed({lpm, frac_r});
    bsel5 = 5'd16 - cmd.idx;
    bsel  = bsel5[3:0];
    ip    = y_r[22:16];
    sh7   = 7'sd14 - ip;
    up1   = {m_r[31:0], 1'b0};
    filt  = sat32((acc_r + prod_r) >>> 16);
    // Adaptive boundary layer from the error magnitude
    if ({2'b00, ae} > tenb) bl_sel = {1'b0, bnd_r, 1'b0};
    else if (ae < {2'b00, bnd_r}) bl_sel = {3'b000, bnd_r[30:1]};
    else bl_sel = {2'b00, bnd_r};
    if (bl_sel == '0) bl_sel = 33'd1;
    // Clamp, upper limit checked first
    if (filt > dmax_r) clamp = dmax_r;
    else if (filt < dmin_r) clamp = dmin_r;
    else clamp = filt;
  end

  always_comb begin
    sts.big        = {1'b0, as32} > bl_r;
    sts.mode       = mode_r;
    sts.alpha_zero = (expo_r == '0);
    sts.alpha_half = (expo_r == EXPO_HALF);
    sts.x_zero     = (s_r == '0);
    sts.norm_done  = nx_r[31] | (lp_r == '0);
    sts.out_free   = !out_valid_r | out_ready;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r <= RST_SLOPE;
      gain_r  <= RST_GAIN;
      eps_r   <= RST_EPS;
      expo_r  <= RST_EXPO;
      mode_r  <= RST_MODE;
      bnd_r   <= RST_BOUNDARY;
      dmin_r  <= RST_DMIN;
      dmax_r  <= RST_DMAX;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SLOPE:    slope_r <= cfg_wdata[30:0];
        CFG_GAIN:     gain_r  <= cfg_wdata[30:0];
        CFG_EPS:      eps_r   <= cfg_wdata[30:0];
        CFG_EXPO:     expo_r  <= (cfg_wdata[16:0] > EXPO_ONE) ? EXPO_ONE : cfg_wdata[16:0];
        CFG_MODE:     mode_r  <= cfg_wdata[1:0];
        CFG_BOUNDARY: bnd_r   <= cfg_wdata[30:0];
        CFG_DMIN:     dmin_r  <= cfg_wdata;
        CFG_DMAX:     dmax_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Shared multiplier, one register stage
  always_ff @(posedge clk) begin
    prod_r <= ma_r * mb_r;
  end

  // Control state: history and output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      fd_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      prev_r      <= e_r;
      fd_r        <= filt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Execute one datapath operation
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        sp_r <= in_setpoint;
        ms_r <= in_measured;
        rt_r <= in_measured_rate;
      end
      OP_ERR: e_r <= sat32(ext66(sp_r) - ext66(ms_r));
      OP_RATE: begin
        ed_r <= (rt_r != '0) ? sat32(ext66(sp_r) - ext66(rt_r)) : sat32(d100);
        ma_r <= {2'b00, slope_r};
        mb_r <= e33;
      end
      OP_SURF: begin
        s_r  <= sat32(ext66(ed_r) + ext66(qm));
        bl_r <= bl_sel;
      end
      OP_SVINIT: begin
        sv_r  <= s_r[31] ? -18'sd65536 : 18'sd65536;
        rem_r <= {2'b00, as32[31:1]};
        num_r <= {as32[0], 16'd0};
        q_r   <= '0;
      end
      OP_DIV: begin
        // Restoring division, one quotient bit per step
        if (trial >= {1'b0, bl_r}) begin
          rem_r <= 33'(trial - {1'b0, bl_r});
          q_r   <= {q_r[15:0], 1'b1};
        end else begin
          rem_r <= trial[32:0];
          q_r   <= {q_r[15:0], 1'b0};
        end
        num_r <= {num_r[15:0], 1'b0};
      end
      OP_SVDIV: sv_r <= s_r[31] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
      OP_PW_ONE:  pw_r <= 32'sd65536;
      OP_PW_ZERO: pw_r <= '0;
      OP_SQ_INIT: begin
        sqv_r <= {16'd0, as32, 16'd0};
        sqr_r <= '0;
        sqb_r <= 64'h4000_0000_0000_0000;
      end
      OP_SQ: begin
        // Square root, one result bit per step
        if (sqv_r >= sq_t) begin
          sqv_r <= sqv_r - sq_t;
          sqr_r <= (sqr_r >> 1) + sqb_r;
        end else begin
          sqr_r <= sqr_r >> 1;
        end
        sqb_r <= sqb_r >> 2;
      end
      OP_PW_SQ: pw_r <= sqr_r[31:0];
      OP_NORM_INIT: begin
        nx_r <= as32;
        lp_r <= 5'd31;
      end
      OP_NORM: begin
        nx_r <= {nx_r[30:0], 1'b0};
        lp_r <= lp_r - 1'b1;
      end
      OP_LG_INIT: begin
        m_r    <= {2'b00, nx_r[31:1]};
        frac_r <= '0;
      end
      OP_LG_M: begin
        ma_r <= {1'b0, m_r[31:0]};
        mb_r <= {1'b0, m_r[31:0]};
      end
      OP_LG_U: begin
        // Square the mantissa; a carry past 2.0 gives the next fraction bit
        m_r    <= mm[31] ? {1'b0, mm[32:1]} : mm;
        frac_r <= {frac_r[14:0], mm[31]};
      end
      OP_LY: begin
        ma_r <= {16'd0, expo_r};
        mb_r <= {{11{lval[21]}}, lval};
      end
      OP_EX_INIT: begin
        y_r <= prod_r[38:16];
        m_r <= 33'd1073741824;
      end
      OP_EX_M: begin
        ma_r <= {1'b0, m_r[31:0]};
        mb_r <= y_r[bsel] ? {2'b00, EXP2_FACT[cmd.idx]} : Q30_ONE;
      end
      OP_EX_U: m_r <= mm;
      OP_EX_F: begin
        // Scale the Q1.30 mantissa by the integer part of the exponent
        if (ip > 7'sd14) pw_r <= up1[31] ? 32'sh7FFF_FFFF : $signed(up1[31:0]);
        else pw_r <= $signed(m_r[31:0] >> sh7[4:0]);
      end
      OP_PSV: begin
        ma_r <= {pw_r[31], pw_r};
        mb_r <= {{15{sv_r[17]}}, sv_r};
      end
      OP_T3: t3_r <= qm;
      OP_KT3: begin
        ma_r <= {2'b00, gain_r};
        mb_r <= {t3_r[31], t3_r};
      end
      OP_KSV: begin
        ma_r <= {2'b00, gain_r};
        mb_r <= {{15{sv_r[17]}}, sv_r};
      end
      OP_T1: t1_r <= qm;
      OP_EPS: begin
        ma_r <= {2'b00, eps_r};
        mb_r <= s33;
      end
      OP_UR_EXP: ur_r <= sat32(-ext66(t1_r) - ext66(qm));
      OP_UR_CON: ur_r <= sat32(-ext66(t1_r));
      OP_CED: begin
        ma_r <= {2'b00, slope_r};
        mb_r <= {ed_r[31], ed_r};
      end
      OP_U: u_r <= sat32(ext66(qm) + ext66(ur_r));
      OP_F1: begin
        ma_r <= FILT_NEW;
        mb_r <= {u_r[31], u_r};
      end
      OP_F1U: begin
        acc_r <= prod_r;
        ma_r  <= FILT_OLD;
        mb_r  <= {fd_r[31], fd_r};
      end
      OP_FIN: begin
        out_drive_r <= clamp;
        out_surf_r  <= s_r;
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_surface = out_surf_r;

  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN) |=> out_valid_r)
    else $error("result not posted");
  a_bl_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SVINIT) |-> bl_r != '0)
    else $error("zero boundary layer");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DIV) |-> rem_r < bl_r)
    else $error("divider remainder out of range");
  a_lg_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LG_M) |-> m_r[32:30] == 3'b001)
    else $error("log mantissa not normalized");

endmodule

// ===== hdl/sliding_mode_controller_unit.sv =====
// Channel      Dir  Handshake      Payload
// in_ch        in   valid/ready    setpoint, measured, measured_rate (Q16.16)
// out_ch       out  valid/ready    drive, surface (Q16.16)
// cfg_*        in   write enable   cfg_index (3 bit), cfg_wdata (32 bit)
//
// One sample at a time through a sequencer and a shared 33x33 multiplier.
// Every law uses the 17-step divider only when |s| is inside the layer.
// Power law adds a square root path for an exponent of one half, or a log/exp path with a normalizer and
// two 16-step loops. The last step holds while the output is still full.
// Synchronous active-low reset restores the configuration registers and clears error/filter history.
// A finished result sits in the output register; the next sample is taken meanwhile.
`timescale 1ns / 1ps

module sliding_mode_controller_unit import smc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  smc_in_if.sink                in_ch,
  smc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]     cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  smc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_setpoint      (in_ch.setpoint),
    .in_measured      (in_ch.measured),
    .in_measured_rate (in_ch.measured_rate),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_drive        (out_ch.drive),
    .out_surface      (out_ch.surface)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for sliding_mode_controller_unit: a bit-exact predictor of the
// Q16.16 sliding-mode control law checks each drive/surface transaction under random stalls.
// Depends on smc_pkg, smc_ifs and the controller RTL.
`timescale 1ns / 1ps

module testbench;
  import smc_pkg::*;

  typedef struct {
    logic signed [31:0] drive;
    logic signed [31:0] surface;
  } ctrl_out_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;

  smc_in_if in_ch ();
  smc_out_if out_ch ();

  sliding_mode_controller_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of registers and history
  longint slope_r, gain_r, eps_r, expo_r, bnd_r;
  law_t law_r;
  longint dmin_r, dmax_r;
  longint prev_err, filt_drive;

  ctrl_out_t expected_q[$];
  int err_count;
  int cycle_count;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qprod(longint a, longint b);
    return clip32((a * b) >>> 16);
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint log2_fix(longint unsigned x);
    int p;
    longint unsigned m;
    longint fr;
    p = 31;
    fr = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (p <= 30) ? (x << (30 - p)) : (x >> 1);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return longint'(p - 16) * 65536 + fr;
  endfunction

  function automatic longint pow2_fix(longint y);
    longint ip, f, sh;
    longint unsigned m, r;
    ip = y >>> 16;
    f = y - ip * 65536;
    m = 64'd1 << 30;
    r = 64'd2 << 30;
    for (int i = 1; i <= 16; i++) begin
      r = root64(r << 30);
      if ((f >> (16 - i)) & 1) m = (m * r) >> 30;
    end
    if (ip <= 14) begin
      sh = 14 - ip;
      if (sh > 62) return 0;
      return clip32(longint'(m >> sh));
    end
    if (ip - 14 > 20) return 64'sd2147483647;
    return clip32(longint'(m << (ip - 14)));
  endfunction

  function automatic longint power_fix(longint unsigned x, longint alpha);
    if (alpha == 0) return 65536;
    if (x == 0) return 0;
    if (alpha == 32768) return clip32(longint'(root64(x << 16)));
    return pow2_fix((alpha * log2_fix(x)) >>> 16);
  endfunction

  function automatic void apply_cfg(cfg_idx_t idx, logic [31:0] v);
    case (idx)
      CFG_SLOPE: slope_r = v[30:0];
      CFG_GAIN: gain_r = v[30:0];
      CFG_EPS: eps_r = v[30:0];
      CFG_EXPO: begin
        expo_r = v[16:0];
        if (expo_r > 65536) expo_r = 65536;
      end
      CFG_MODE: law_r = law_t'(v[1:0]);
      CFG_BOUNDARY: bnd_r = v[30:0];
      CFG_DMIN: dmin_r = longint'(signed'(v));
      default: dmax_r = longint'(signed'(v));
    endcase
  endfunction

  // Compute drive and surface for one sample, advance history
  function automatic ctrl_out_t control_step(logic signed [31:0] sp, logic signed [31:0] ms,
                                              logic signed [31:0] rt);
    ctrl_out_t res;
    longint e, ed, s, ae, bl, sv, ur, u, f, d, x;
    e = clip32(longint'(sp) - longint'(ms));
    if (rt != 0) ed = clip32(longint'(sp) - longint'(rt));
    else ed = clip32((e - prev_err) * 100);
    s = clip32(ed + qprod(slope_r, e));
    ae = e < 0 ? -e : e;
    if (ae > 10 * bnd_r) bl = 2 * bnd_r;
    else if (ae < bnd_r) bl = bnd_r >>> 1;
    else bl = bnd_r;
    if (bl < 1) bl = 1;
    if (s > bl) sv = 65536;
    else if (s < -bl) sv = -65536;
    else sv = (s * 65536) / bl;
    if (law_r == LAW_EXP) begin
      ur = clip32(-qprod(gain_r, sv) - qprod(eps_r, s));
    end else if (law_r == LAW_POWER) begin
      x = s < 0 ? -s : s;
      ur = clip32(-qprod(gain_r, qprod(power_fix(x, expo_r), sv)));
    end else begin
      ur = clip32(-qprod(gain_r, sv));
    end
    u = clip32(qprod(slope_r, ed) + ur);
    f = clip32((19661 * u + 45875 * filt_drive) >>> 16);
    filt_drive = f;
    prev_err = e;
    d = f;
    if (d > dmax_r) d = dmax_r;
    else if (d < dmin_r) d = dmin_r;
    res.drive = d[31:0];
    res.surface = s[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin
    ctrl_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected", out_ch.drive, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.drive !== want.drive) report_mismatch("drive", out_ch.drive, want.drive);
        if (out_ch.surface !== want.surface)
          report_mismatch("surface", out_ch.surface, want.surface);
      end
    end
  end

  // Result-side stalls
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 10);
  end

  // Drive one transaction; valid stays high into the next send unless an idle cycle drops it
  task automatic send_sample(logic signed [31:0] sp, logic signed [31:0] ms,
                             logic signed [31:0] rt);
    while (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.setpoint <= sp;
    in_ch.measured <= ms;
    in_ch.measured_rate <= rt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(control_step(sp, ms, rt));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, v);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h8000_0000 ^ ($urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF);
      2: return 32'h0;
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  task automatic run_random(int n);
    logic [31:0] sp, ms, rt;
    for (int i = 0; i < n; i++) begin
      sp = rand_field();
      ms = ($urandom_range(3) == 0) ? rand_field() : sp + $urandom_range(40000) - 20000;
      rt = ($urandom_range(2) == 0) ? 32'h0 : rand_field();
      send_sample(sp, ms, rt);
    end
  endtask

  task automatic test_edges();
    logic [31:0] ext [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    for (int i = 0; i < 5; i++) send_sample(ext[i], ext[4 - i], ext[(i + 2) % 5]);
    send_sample(32'h10000, 32'h10000, 32'h0);
    send_sample(32'h20000, 32'h8000, 32'h0);
    send_sample(32'h0, 32'h400, 32'h123);
    drain();
  endtask

  task automatic test_laws();
    law_t laws [4] = '{LAW_CONST, LAW_EXP, LAW_POWER, LAW_CONST2};
    for (int l = 0; l < 4; l++) begin
      write_cfg(CFG_MODE, laws[l]);
      send_sample(32'h0, 32'h0, 32'h0);
      send_sample(32'h30000, 32'h10000, 32'h0);
      send_sample(32'hFFF0_0000, 32'h10, 32'h5);
      run_random(40);
      drain();
    end
  endtask

  task automatic test_power_exponents();
    logic [31:0] ex [5] = '{32'h0, 32'h8000, 32'h10000, 32'h1FFFF, 32'h4000};
    write_cfg(CFG_MODE, LAW_POWER);
    for (int i = 0; i < 5; i++) begin
      write_cfg(CFG_EXPO, ex[i]);
      run_random(30);
      drain();
    end
    write_cfg(CFG_EXPO, $urandom_range(65535));
    run_random(30);
    drain();
  endtask

  task automatic test_settings();
    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_SLOPE, p == 0 ? 32'h7FFF_FFFF : p == 1 ? 32'h0 : $urandom_range(200000));
      write_cfg(CFG_GAIN, p == 0 ? 32'h7FFF_FFFF : p == 1 ? 32'h0 : $urandom_range(200000));
      write_cfg(CFG_EPS, p == 0 ? 32'h7FFF_FFFF : p == 1 ? 32'h0 : $urandom_range(200000));
      write_cfg(CFG_BOUNDARY, p == 0 ? 32'h7FFF_FFFF : p == 1 ? 32'h1 : $urandom_range(100000));
      // Inverted limits on one pass
      write_cfg(CFG_DMIN, p == 2 ? 32'h0001_0000 : p == 0 ? 32'h8000_0000 : rand_field());
      write_cfg(CFG_DMAX, p == 2 ? 32'hFFFF_0000 : p == 0 ? 32'h7FFF_FFFF : rand_field());
      write_cfg(CFG_MODE, $urandom_range(3));
      write_cfg(CFG_EXPO, $urandom_range(65536));
      calm = (p == 3);
      run_random(40);
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SLOPE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.setpoint = '0;
    in_ch.measured = '0;
    in_ch.measured_rate = '0;
    slope_r = RST_SLOPE;
    gain_r = RST_GAIN;
    eps_r = RST_EPS;
    expo_r = RST_EXPO;
    law_r = law_t'(RST_MODE);
    bnd_r = RST_BOUNDARY;
    dmin_r = longint'(RST_DMIN);
    dmax_r = longint'(RST_DMAX);
    prev_err = 0;
    filt_drive = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_laws();
    test_power_exponents();
    test_settings();
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// ===== sliding_mode_controller_unit.f =====
hdl/smc_pkg.sv
hdl/smc_ifs.sv
hdl/smc_ctrl.sv
hdl/smc_dp.sv
hdl/sliding_mode_controller_unit.sv
tb/sv/testbench.sv
